>>> rtl/dht_pkg.sv
package dht_pkg;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_SEARCH = 2'd1;
  localparam logic [1:0] CMD_REMOVE = 2'd2;

  localparam logic [1:0] OUT_DONE     = 2'd0;
  localparam logic [1:0] OUT_NOTFOUND = 2'd1;
  localparam logic [1:0] OUT_FULL     = 2'd2;

  localparam logic [1:0] MARK_EMPTY = 2'd0;
  localparam logic [1:0] MARK_USED  = 2'd1;
  localparam logic [1:0] MARK_GONE  = 2'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic signed [31:0] key;
    logic [7:0]  age;
    logic [31:0] weight_bits;
    logic [31:0] height_bits;
  } req_t;

  typedef struct packed {
    logic [1:0]  outcome;
    logic [7:0]  slot;
    logic [7:0]  found_age;
    logic [31:0] found_weight_bits;
    logic [31:0] found_height_bits;
  } rsp_t;

  typedef struct packed {
    logic load;
    logic hash_step;
    logic rd;
    logic advance;
    logic wr_ins;
    logic wr_del;
    logic respond;
    logic [1:0] outcome;
    logic hit;
  } ctl_t;

  typedef struct packed {
    logic hash_done;
    logic is_used;
    logic is_empty;
    logic key_eq;
    logic last_probe;
  } sts_t;

endpackage

>>> rtl/dht_datapath.sv
module dht_datapath #(
  parameter int MAX_SLOTS = 256
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [8:0]      table_size_i,
  input  dht_pkg::req_t   req_i,
  input  dht_pkg::ctl_t   ctl_i,
  output dht_pkg::sts_t   sts_o,
  output logic            result_valid_o,
  output dht_pkg::rsp_t   result_o
);

  localparam int AW = (MAX_SLOTS > 2) ? $clog2(MAX_SLOTS) : 1;
  localparam int SW = $clog2(MAX_SLOTS + 1);
  localparam int RW = SW + 1;

  logic [1:0]  mark_q [MAX_SLOTS];
  logic [MAX_SLOTS-1:0] vld_q;
  logic [31:0] key_mem [MAX_SLOTS];
  logic [71:0] pay_mem [MAX_SLOTS];

  dht_pkg::req_t req_q;
  logic [SW-1:0] m_q, m1_q;
  logic [RW-1:0] ra_q, rb_q;
  logic [5:0]  bit_q;
  logic [AW-1:0] pos_q, step_q;
  logic [SW-1:0] cnt_q;
  logic [1:0]  mark_rd_q;
  logic [31:0] key_rd_q;
  logic [71:0] pay_rd_q;
  logic        result_valid_q;
  dht_pkg::rsp_t result_q, result_d;

  logic [SW-1:0] m_sel;
  logic [RW-1:0] ta, tb, a_fix, b_fix;
  logic [SW:0]   nxt_sum;

  function automatic logic abs_key_bit(input logic [31:0] k, input logic [5:0] b);
    logic [32:0] a;
    a = k[31] ? (33'd0 - {1'b1, k}) : {1'b0, k};
    return a[b[5:0] > 6'd32 ? 6'd0 : b];
  endfunction

  always_comb begin
    if (table_size_i < 9'd2) begin
      m_sel = SW'(2);
    end else if ({{(32-9){1'b0}}, table_size_i} > 32'(MAX_SLOTS)) begin
      m_sel = SW'(MAX_SLOTS);
    end else begin
      m_sel = SW'(table_size_i);
    end
  end

  always_comb begin
    ta = {ra_q[RW-2:0], abs_key_bit(req_q.key, bit_q)};
    tb = {rb_q[RW-2:0], abs_key_bit(req_q.key, bit_q)};
    if (ta >= RW'(m_q)) ta = ta - RW'(m_q);
    if (tb >= RW'(m1_q)) tb = tb - RW'(m1_q);
    a_fix = ta;
    b_fix = tb;
    if (req_q.key[31] && a_fix != '0) a_fix = RW'(m_q) - a_fix;
    if (req_q.key[31] && b_fix != '0) b_fix = RW'(m1_q) - b_fix;
    nxt_sum = {1'b0, SW'(pos_q)} + {1'b0, SW'(step_q)};
    if (nxt_sum >= (SW+1)'(m_q)) nxt_sum = nxt_sum - (SW+1)'(m_q);
  end

  always_comb begin
    result_d = '0;
    result_d.outcome = ctl_i.outcome;
    if (ctl_i.hit) begin
      result_d.slot = 8'(pos_q);
      if (req_q.command == dht_pkg::CMD_SEARCH) begin
        result_d.found_age         = pay_rd_q[71:64];
        result_d.found_weight_bits = pay_rd_q[63:32];
        result_d.found_height_bits = pay_rd_q[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
      result_valid_q <= 1'b0;
      bit_q <= '0;
      cnt_q <= '0;
    end else begin
      result_valid_q <= ctl_i.respond;
      if (ctl_i.load) begin
        bit_q <= 6'd32;
      end else if (ctl_i.hash_step) begin
        bit_q <= bit_q - 6'd1;
      end
      if (ctl_i.hash_step && bit_q == 6'd0) cnt_q <= SW'(1);
      else if (ctl_i.advance) cnt_q <= cnt_q + SW'(1);
      if (ctl_i.wr_ins || ctl_i.wr_del) vld_q[pos_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      req_q <= req_i;
      m_q   <= m_sel;
      m1_q  <= m_sel - SW'(1);
      ra_q  <= '0;
      rb_q  <= '0;
    end else if (ctl_i.hash_step) begin
      ra_q <= ta;
      rb_q <= tb;
      if (bit_q == 6'd0) begin
        pos_q  <= AW'(a_fix);
        step_q <= AW'(b_fix + RW'(1));
      end
    end else if (ctl_i.advance) begin
      pos_q <= AW'(nxt_sum);
    end
    if (ctl_i.rd) begin
      mark_rd_q <= vld_q[pos_q] ? mark_q[pos_q] : dht_pkg::MARK_EMPTY;
      key_rd_q  <= vld_q[pos_q] ? key_mem[pos_q] : 32'hFFFF_FFFF;
      pay_rd_q  <= pay_mem[pos_q];
    end
    if (ctl_i.wr_ins) begin
      mark_q[pos_q]  <= dht_pkg::MARK_USED;
      key_mem[pos_q] <= req_q.key;
      pay_mem[pos_q] <= {req_q.age, req_q.weight_bits, req_q.height_bits};
    end else if (ctl_i.wr_del) begin
      mark_q[pos_q]  <= dht_pkg::MARK_GONE;
      key_mem[pos_q] <= 32'hFFFF_FFFF;
    end
    if (ctl_i.respond) begin
      result_q <= result_d;
    end
  end

  assign sts_o.hash_done  = (bit_q == 6'd0);
  assign sts_o.is_used    = (mark_rd_q == dht_pkg::MARK_USED);
  assign sts_o.is_empty   = (mark_rd_q == dht_pkg::MARK_EMPTY);
  assign sts_o.key_eq     = (key_rd_q == req_q.key);
  assign sts_o.last_probe = (cnt_q >= m_q);
  assign result_valid_o   = result_valid_q;
  assign result_o         = result_q;

endmodule

>>> rtl/dht_ctrl.sv
module dht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic [1:0]    command_i,
  input  dht_pkg::sts_t sts_i,
  output logic          busy,
  output dht_pkg::ctl_t ctl_o
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_HASH  = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CHECK = 3'd3;
  localparam logic [2:0] S_RESP  = 3'd4;

  logic [2:0] state_q, state_d;
  logic [1:0] cmd_q;
  logic [1:0] out_q, out_d;
  logic       hit_q, hit_d;

  always_comb begin
    state_d = state_q;
    out_d = out_q;
    hit_d = hit_q;
    ctl_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          ctl_o.load = 1'b1;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        ctl_o.hash_step = 1'b1;
        if (sts_i.hash_done) begin
          if (cmd_q inside {dht_pkg::CMD_INSERT, dht_pkg::CMD_SEARCH,
                            dht_pkg::CMD_REMOVE}) begin
            state_d = S_READ;
          end else begin
            out_d = dht_pkg::OUT_NOTFOUND;
            hit_d = 1'b0;
            state_d = S_RESP;
          end
        end
      end
      S_READ: begin
        ctl_o.rd = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (cmd_q == dht_pkg::CMD_INSERT) begin
          if (!sts_i.is_used) begin
            ctl_o.wr_ins = 1'b1;
            out_d = dht_pkg::OUT_DONE;
            hit_d = 1'b1;
            state_d = S_RESP;
          end else if (sts_i.last_probe) begin
            out_d = dht_pkg::OUT_FULL;
            hit_d = 1'b0;
            state_d = S_RESP;
          end else begin
            ctl_o.advance = 1'b1;
            state_d = S_READ;
          end
        end else begin
          if (sts_i.is_used && sts_i.key_eq) begin
            ctl_o.wr_del = (cmd_q == dht_pkg::CMD_REMOVE);
            out_d = dht_pkg::OUT_DONE;
            hit_d = 1'b1;
            state_d = S_RESP;
          end else if (sts_i.is_empty || sts_i.last_probe) begin
            out_d = dht_pkg::OUT_NOTFOUND;
            hit_d = 1'b0;
            state_d = S_RESP;
          end else begin
            ctl_o.advance = 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_RESP: begin
        ctl_o.respond = 1'b1;
        ctl_o.outcome = out_q;
        ctl_o.hit = hit_q;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q <= '0;
      out_q <= '0;
      hit_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_q <= out_d;
      hit_q <= hit_d;
      if (ctl_o.load) cmd_q <= command_i;
    end
  end

  assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/double_hash_table.sv
// One transaction at a time: a start is taken only while idle, and busy stays
//   high until the response is registered. The key is first reduced bit-serially
//   into a home slot and a probe step (double hashing); each probe then reads
//   one slot and then checks it.
// Reset: table_size returns to 256 and all slots read as empty with key -1.
// The receiver cannot stall: done_o pulses for one cycle with the result.
module double_hash_table #(
  parameter int MAX_SLOTS = 256
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  dht_pkg::req_t req_i,
  output logic          done_o,
  output dht_pkg::rsp_t rsp_o,
  input  logic          cfg_we_i,
  input  logic [8:0]    cfg_wdata_i
);

  logic [8:0] table_size_q;
  dht_pkg::ctl_t ctl;
  dht_pkg::sts_t sts;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= 9'd256;
    end else if (cfg_we_i) begin
      table_size_q <= cfg_wdata_i;
    end
  end

  dht_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start     (start),
    .command_i (req_i.command),
    .sts_i     (sts),
    .busy      (busy),
    .ctl_o     (ctl)
  );

  dht_datapath #(.MAX_SLOTS(MAX_SLOTS)) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .table_size_i   (table_size_q),
    .req_i          (req_i),
    .ctl_i          (ctl),
    .sts_o          (sts),
    .result_valid_o (done_o),
    .result_o       (rsp_o)
  );

  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy)) else $error("done without transaction");
  a_one_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctl.wr_ins && ctl.wr_del)) else $error("double write");
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("start not taken");

endmodule
